>>> design/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned SlotW = 4;
  localparam int unsigned PortW = 4;

  typedef struct packed {
    logic [AddrW-1:0] prefix;
    logic [AddrW-1:0] mask;
    logic [AddrW-1:0] gateway;
    logic [PortW-1:0] port;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic step;
    logic valid;
  } cmp_ctrl_t;

endpackage

`default_nettype wire

>>> design/longest_prefix_match_lookup_unit.sv
`default_nettype none

// IPv4 longest-prefix-match routing table with ENTRIES slots. A word with
// func = 0 loads one slot; its all-zero result strobes on done the next
// cycle and busy stays low. A word with func = 1 scans the table through
// one shared prefix comparator, one slot per cycle out of a registered-read
// RAM; the result strobes on done once the last slot has passed the RAM
// read register, the comparator and the DONE state, with busy high until
// then. Outputs hold results for exactly the one cycle that done is high;
// the receiver cannot stall them. Valid bits live in flops, clear on reset.
module longest_prefix_match_lookup_unit #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          func,
  input  wire logic [lpm_pkg::SlotW-1:0]     slot,
  input  wire logic                          slot_valid,
  input  wire logic [lpm_pkg::AddrW-1:0]     route_prefix,
  input  wire logic [lpm_pkg::AddrW-1:0]     route_mask,
  input  wire logic [lpm_pkg::AddrW-1:0]     route_gateway,
  input  wire logic [lpm_pkg::PortW-1:0]     route_port,
  input  wire logic [lpm_pkg::AddrW-1:0]     lookup_addr,
  output logic                               done,
  output logic                               hit,
  output logic [lpm_pkg::SlotW-1:0]          match_slot,
  output logic [lpm_pkg::AddrW-1:0]          match_mask,
  output logic [lpm_pkg::PortW-1:0]          out_port,
  output logic [lpm_pkg::AddrW-1:0]          next_hop
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned XW = ((IW > lpm_pkg::SlotW) ? IW : lpm_pkg::SlotW) + 1;
  localparam int unsigned EW = $bits(lpm_pkg::entry_t);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]               state;
  logic [IW-1:0]            idx;
  logic [IW-1:0]            rd_idx;
  logic                     rd_step;
  logic                     rd_valid;
  logic [ENTRIES-1:0]       valid;
  logic [lpm_pkg::AddrW-1:0] addr;

  logic                     accept;
  logic                     wr_en;
  logic [XW-1:0]            slot_ext;
  logic [IW-1:0]            wr_addr;
  lpm_pkg::entry_t          wr_ent;
  logic [EW-1:0]            rd_data;
  lpm_pkg::entry_t          rd_ent;
  lpm_pkg::cmp_ctrl_t       ctrl;
  logic                     found;
  logic [IW-1:0]            best_idx;
  lpm_pkg::entry_t          best;
  logic [XW-1:0]            best_ext;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign slot_ext = XW'(slot);
  assign wr_addr  = slot_ext[IW-1:0];
  assign wr_en    = accept && !func && (slot_ext < XW'(ENTRIES));
  assign wr_ent   = '{prefix: route_prefix, mask: route_mask,
                      gateway: route_gateway, port: route_port};
  assign rd_ent   = lpm_pkg::entry_t'(rd_data);
  assign best_ext = XW'(best_idx);

  assign ctrl.clear = accept && func;
  assign ctrl.step  = rd_step;
  assign ctrl.valid = rd_valid;

  lpm_ram #(
    .WIDTH (EW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (EW'(wr_ent)),
    .raddr (idx),
    .rdata (rd_data)
  );

  lpm_cmp #(
    .IW (IW)
  ) u_cmp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .ent      (rd_ent),
    .idx      (rd_idx),
    .addr     (addr),
    .found    (found),
    .best_idx (best_idx),
    .best     (best)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      rd_step <= 1'b0;
    end else begin
      rd_step <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && func) begin
            idx   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_step <= 1'b1;
          if (idx == IW'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && func) begin
      addr <= lookup_addr;
    end
    rd_idx   <= idx;
    rd_valid <= valid[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (accept && !func) || (state == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && found) begin
      hit        <= 1'b1;
      match_slot <= best_ext[lpm_pkg::SlotW-1:0];
      match_mask <= best.mask;
      out_port   <= best.port;
      next_hop   <= (best.gateway != '0 && best.gateway != best.prefix) ?
                    best.gateway : addr;
    end else begin
      hit        <= 1'b0;
      match_slot <= '0;
      match_mask <= '0;
      out_port   <= '0;
      next_hop   <= '0;
    end
  end

endmodule

`default_nettype wire

>>> design/lpm_ram.sv
`default_nettype none

module lpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/lpm_cmp.sv
`default_nettype none

module lpm_cmp #(
  parameter int unsigned IW = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lpm_pkg::cmp_ctrl_t            ctrl,
  input  wire lpm_pkg::entry_t               ent,
  input  wire logic [IW-1:0]                 idx,
  input  wire logic [lpm_pkg::AddrW-1:0]     addr,
  output logic                               found,
  output logic [IW-1:0]                      best_idx,
  output lpm_pkg::entry_t                    best
);

  logic match;
  logic take;

  assign match = ((addr & ent.mask) == (ent.prefix & ent.mask));
  assign take  = ctrl.step && ctrl.valid && match && (!found || (ent.mask > best.mask));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx <= idx;
      best     <= ent;
    end
  end

endmodule

`default_nettype wire
